@@ src/dpae_pkg.sv @@
// Shared types and constants for the data-processing ALU execute unit.
// Opcode codes, encoding checks and the execute result record.
// No dependencies.
`default_nettype none

package dpae_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned REG_DEPTH = 16;
	localparam int unsigned REG_IDX_W = $clog2(REG_DEPTH);

	localparam logic [3:0] OP_AND = 4'd0;
	localparam logic [3:0] OP_EOR = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_RSB = 4'd3;
	localparam logic [3:0] OP_ADD = 4'd4;
	localparam logic [3:0] OP_ADC = 4'd5;
	localparam logic [3:0] OP_SBC = 4'd6;
	localparam logic [3:0] OP_RSC = 4'd7;
	localparam logic [3:0] OP_TST = 4'd8;
	localparam logic [3:0] OP_TEQ = 4'd9;
	localparam logic [3:0] OP_CMP = 4'd10;
	localparam logic [3:0] OP_CMN = 4'd11;
	localparam logic [3:0] OP_ORR = 4'd12;
	localparam logic [3:0] OP_MOV = 4'd13;
	localparam logic [3:0] OP_BIC = 4'd14;
	localparam logic [3:0] OP_MVN = 4'd15;

	localparam logic [5:0]        COND_REQUIRED  = 6'd56;
	localparam logic [DATA_W-1:0] ILLEGAL_STATUS = 32'd1;

	localparam int unsigned FLAG_N = 31;
	localparam int unsigned FLAG_Z = 30;
	localparam int unsigned FLAG_C = 29;
	localparam int unsigned FLAG_V = 28;

	typedef struct packed {
		logic                 wr_en;
		logic [REG_IDX_W-1:0] dest;
		logic [DATA_W-1:0]    value;
		logic [DATA_W-1:0]    status;
		logic                 illegal;
	} dpae_res_t;

endpackage

`default_nettype wire

@@ src/data_processing_alu_execute_unit.sv @@
// Pipeline: two register stages (s1 and the output register).
// Throughput: one request per cycle unless the output stalls; register file read
// at acceptance, written back as s1 advances, with a bypass for the write that lands
// on the same edge as a read. Reset: arst_n clears all registers to zero (per-entry
// valid bits), status to zero, and empties the pipeline.
// Uses dpae_pkg and dpae_alu.
`default_nettype none

module data_processing_alu_execute_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                mode,
	input  wire logic [dpae_pkg::DATA_W-1:0]         instr,
	input  wire logic [dpae_pkg::REG_IDX_W-1:0]      load_index,
	input  wire logic [dpae_pkg::DATA_W-1:0]         load_value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     reg_written,
	output logic [dpae_pkg::REG_IDX_W-1:0]           dest_index,
	output logic [dpae_pkg::DATA_W-1:0]              write_value,
	output logic [dpae_pkg::DATA_W-1:0]              status_word,
	output logic                                     illegal
);
	import dpae_pkg::*;

	logic [DATA_W-1:0]    rf_mem [REG_DEPTH];
	logic [REG_DEPTH-1:0] rf_vld_q;
	logic [DATA_W-1:0]    status_q;

	logic                 vld_s1;
	logic                 mode_s1;
	logic [DATA_W-1:0]    instr_s1;
	logic [REG_IDX_W-1:0] load_index_s1;
	logic [DATA_W-1:0]    load_value_s1;
	logic [DATA_W-1:0]    rd_a_s1;
	logic [DATA_W-1:0]    rd_b_s1;
	logic                 a_vld_s1;
	logic                 b_vld_s1;

	logic                 byp_vld_q;
	logic [REG_IDX_W-1:0] byp_idx_q;
	logic [DATA_W-1:0]    byp_val_q;

	logic                 out_vld_q;
	logic                 reg_written_q;
	logic [REG_IDX_W-1:0] dest_index_q;
	logic [DATA_W-1:0]    write_value_q;
	logic [DATA_W-1:0]    status_word_q;
	logic                 illegal_q;

	logic                 accept;
	logic                 advance;
	logic [REG_IDX_W-1:0] rn_in;
	logic [REG_IDX_W-1:0] rm_in;
	logic [REG_IDX_W-1:0] rn_s1;
	logic [REG_IDX_W-1:0] rm_s1;
	logic [DATA_W-1:0]    rn_val;
	logic [DATA_W-1:0]    rm_val;
	dpae_res_t            alu_res;
	dpae_res_t            fin;

	assign advance  = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign rn_in = instr[19:16];
	assign rm_in = instr[3:0];
	assign rn_s1 = instr_s1[19:16];
	assign rm_s1 = instr_s1[3:0];

	always_comb begin
		if (byp_vld_q && byp_idx_q == rn_s1)
			rn_val = byp_val_q;
		else
			rn_val = a_vld_s1 ? rd_a_s1 : '0;
		if (byp_vld_q && byp_idx_q == rm_s1)
			rm_val = byp_val_q;
		else
			rm_val = b_vld_s1 ? rd_b_s1 : '0;
	end

	dpae_alu u_alu (
		.instr     (instr_s1),
		.rn_val    (rn_val),
		.rm_val    (rm_val),
		.status_in (status_q),
		.res       (alu_res)
	);

	always_comb begin
		if (mode_s1) begin
			fin         = '0;
			fin.wr_en   = 1'b1;
			fin.dest    = load_index_s1;
			fin.value   = load_value_s1;
			fin.status  = status_q;
		end else begin
			fin = alu_res;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fin.wr_en)
			rf_mem[fin.dest] <= fin.value;
		if (accept) begin
			rd_a_s1 <= rf_mem[rn_in];
			rd_b_s1 <= rf_mem[rm_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= '0;
			status_q  <= '0;
			vld_s1    <= 1'b0;
			byp_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (advance) begin
				status_q <= fin.status;
				if (fin.wr_en)
					rf_vld_q[fin.dest] <= 1'b1;
			end
			if (accept)
				byp_vld_q <= advance && fin.wr_en;
			if (accept)
				vld_s1 <= 1'b1;
			else if (advance)
				vld_s1 <= 1'b0;
			if (advance)
				out_vld_q <= 1'b1;
			else if (!out_stall)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1       <= mode;
			instr_s1      <= instr;
			load_index_s1 <= load_index;
			load_value_s1 <= load_value;
			a_vld_s1      <= rf_vld_q[rn_in];
			b_vld_s1      <= rf_vld_q[rm_in];
			byp_idx_q     <= fin.dest;
			byp_val_q     <= fin.value;
		end
		if (advance) begin
			reg_written_q <= fin.wr_en;
			dest_index_q  <= fin.dest;
			write_value_q <= fin.value;
			status_word_q <= fin.status;
			illegal_q     <= fin.illegal;
		end
	end

	assign out_valid   = out_vld_q;
	assign reg_written = reg_written_q;
	assign dest_index  = dest_index_q;
	assign write_value = write_value_q;
	assign status_word = status_word_q;
	assign illegal     = illegal_q;

endmodule

`default_nettype wire

@@ src/dpae_alu.sv @@
// Decode, encoding check and arithmetic for one data-processing request.
// Takes forwarded operands and the current status; uses dpae_pkg.
`default_nettype none

module dpae_alu (
	input  wire logic [dpae_pkg::DATA_W-1:0] instr,
	input  wire logic [dpae_pkg::DATA_W-1:0] rn_val,
	input  wire logic [dpae_pkg::DATA_W-1:0] rm_val,
	input  wire logic [dpae_pkg::DATA_W-1:0] status_in,
	output dpae_pkg::dpae_res_t              res
);
	import dpae_pkg::*;

	logic [3:0]        opc;
	logic              ibit;
	logic              sbit;
	logic              bad;
	logic [DATA_W-1:0] op2;
	logic [DATA_W-1:0] x;
	logic [DATA_W-1:0] y;
	logic              k;
	logic              is_sub;
	logic              is_logic;
	logic              writes;
	logic [DATA_W:0]   ext;
	logic [DATA_W-1:0] r;
	logic              cflag;
	logic              vflag;

	always_comb begin
		opc  = instr[24:21];
		ibit = instr[25];
		sbit = instr[20];
		op2  = ibit ? {{(DATA_W-8){1'b0}}, instr[7:0]} : rm_val;

		bad = (instr[31:26] != COND_REQUIRED) || (instr[11:8] != 4'd0) ||
			(!ibit && (instr[7:4] != 4'd0));
		if (opc[3:2] == 2'b10 && !sbit)
			bad = 1'b1;
		if ((opc == OP_MOV || opc == OP_MVN) && instr[19:16] != 4'd0)
			bad = 1'b1;

		x        = rn_val;
		y        = op2;
		k        = 1'b0;
		is_sub   = 1'b0;
		is_logic = 1'b1;
		writes   = 1'b1;
		r        = '0;

		unique case (opc) inside
			OP_AND, OP_TST: r = rn_val & op2;
			OP_EOR, OP_TEQ: r = rn_val ^ op2;
			OP_SUB, OP_CMP: begin
				is_sub   = 1'b1;
				is_logic = 1'b0;
			end
			OP_RSB: begin
				x        = op2;
				y        = rn_val;
				is_sub   = 1'b1;
				is_logic = 1'b0;
			end
			OP_ADD, OP_CMN: is_logic = 1'b0;
			OP_ADC: begin
				k        = status_in[FLAG_C];
				is_logic = 1'b0;
			end
			OP_SBC: begin
				k        = status_in[FLAG_C];
				is_sub   = 1'b1;
				is_logic = 1'b0;
			end
			OP_RSC: begin
				x        = op2;
				y        = rn_val;
				k        = status_in[FLAG_C];
				is_sub   = 1'b1;
				is_logic = 1'b0;
			end
			OP_ORR: r = rn_val | op2;
			OP_MOV: r = op2;
			OP_BIC: r = rn_val & ~op2;
			OP_MVN: r = ~op2;
			default: r = '0;
		endcase

		if (opc[3:2] == 2'b10)
			writes = 1'b0;

		if (is_sub)
			ext = {1'b0, x} - {1'b0, y} - {{DATA_W{1'b0}}, k};
		else
			ext = {1'b0, x} + {1'b0, y} + {{DATA_W{1'b0}}, k};

		if (!is_logic)
			r = ext[DATA_W-1:0];
		cflag = ext[DATA_W];
		if (is_sub)
			vflag = ((x[DATA_W-1] ^ y[DATA_W-1]) & (x[DATA_W-1] ^ r[DATA_W-1]));
		else
			vflag = (~(x[DATA_W-1] ^ y[DATA_W-1]) & (x[DATA_W-1] ^ r[DATA_W-1]));

		res = '0;
		if (bad) begin
			res.status  = ILLEGAL_STATUS;
			res.illegal = 1'b1;
		end else begin
			res.status = status_in;
			if (sbit) begin
				res.status         = '0;
				res.status[FLAG_N] = r[DATA_W-1];
				res.status[FLAG_Z] = (r == '0);
				if (!is_logic) begin
					res.status[FLAG_C] = cflag;
					res.status[FLAG_V] = vflag;
				end
			end
			if (writes) begin
				res.wr_en = 1'b1;
				res.dest  = instr[15:12];
				res.value = r;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/dpae_checker.sv @@
// Port-level checks for the data-processing ALU execute unit.
// Bound to data_processing_alu_execute_unit; uses dpae_pkg.
`default_nettype none

module dpae_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                out_valid,
	input  wire logic                                out_stall,
	input  wire logic                                reg_written,
	input  wire logic [dpae_pkg::REG_IDX_W-1:0]      dest_index,
	input  wire logic [dpae_pkg::DATA_W-1:0]         write_value,
	input  wire logic [dpae_pkg::DATA_W-1:0]         status_word,
	input  wire logic                                illegal
);
	import dpae_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(write_value) &&
			$stable(status_word) && $stable(dest_index))
		else $error("stalled result changed");

	a_illegal_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && illegal |-> status_word == ILLEGAL_STATUS && !reg_written)
		else $error("rejected request wrote or left wrong status");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_written |-> dest_index == '0 && write_value == '0)
		else $error("non-writing result carries a destination");

	a_zero_not_neg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_word[FLAG_Z] |-> !status_word[FLAG_N])
		else $error("Z and N both set");

endmodule

bind data_processing_alu_execute_unit dpae_checker u_dpae_checker (.*);

`default_nettype wire
